@@ design/stos_pkg.sv @@
// shared types and constants for the stepped triangle output sequencer
package stos_pkg;

  localparam int PERIOD_W  = 10;
  localparam int LEVEL_W   = 5;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 4;
  localparam int PROD_W    = DATA_W + LEVEL_W + 1;
  localparam int MAG_W     = DATA_W + LEVEL_W - 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(10);
  localparam logic [LEVEL_W-1:0]  HIGH_RST     = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0]  LOW_RST      = LEVEL_W'(1);
  localparam logic [DATA_W-1:0]   SETPOINT_RST = '0;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST    = LEVEL_W'(1);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_PERIOD   = 2'd0,
    REG_HIGH     = 2'd1,
    REG_LOW      = 2'd2,
    REG_SETPOINT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ticks;
    logic [LEVEL_W-1:0]  high_step;
    logic [LEVEL_W-1:0]  low_step;
    logic [DATA_W-1:0]   setpoint;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/stos_cfg_regs.sv @@
// apb register bank holding period, step limits and setpoint
module stos_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stos_pkg::ADDR_W-1:0]  paddr,
  input  logic [stos_pkg::DATA_W-1:0]  pwdata,
  output logic [stos_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output stos_pkg::cfg_t               cfg
);
  import stos_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks <= PERIOD_RST;
      cfg_r.high_step    <= HIGH_RST;
      cfg_r.low_step     <= LOW_RST;
      cfg_r.setpoint     <= SETPOINT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PERIOD:   cfg_r.period_ticks <= pwdata[PERIOD_W-1:0];
        REG_HIGH:     cfg_r.high_step    <= pwdata[LEVEL_W-1:0];
        REG_LOW:      cfg_r.low_step     <= pwdata[LEVEL_W-1:0];
        REG_SETPOINT: cfg_r.setpoint     <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD:   prdata = DATA_W'(cfg_r.period_ticks);
      REG_HIGH:     prdata = DATA_W'(cfg_r.high_step);
      REG_LOW:      prdata = DATA_W'(cfg_r.low_step);
      REG_SETPOINT: prdata = cfg_r.setpoint;
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/stos_div.sv @@
// restoring divider, one quotient bit per cycle, magnitude by high step
module stos_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [stos_pkg::MAG_W-1:0]   dividend,
  input  logic [stos_pkg::LEVEL_W-1:0] divisor,
  output logic [stos_pkg::MAG_W-1:0]   quotient,
  output stos_pkg::div_stat_t          stat
);
  import stos_pkg::*;

  logic [MAG_W-1:0]   acc_r, acc_nxt;
  logic [LEVEL_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [LEVEL_W:0]   rem_sh;
  logic [LEVEL_W:0]   rem_sub;
  logic               ge;

  // shift next dividend bit into the partial remainder
  assign rem_sh  = {rem_r, acc_r[MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[MAG_W-2:0], ge};
      rem_nxt = ge ? rem_sub[LEVEL_W-1:0] : rem_sh[LEVEL_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r ##1 !done_r)
    else $error("divider done is not a single pulse after busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < CNT_W'(DIV_STEPS))
    else $error("divider step count overran");

endmodule

@@ design/stepped_triangle_output_sequencer.sv @@
// Stepped triangle output sequencer: a restart request, a tick with the source off, or a tick
// that does not complete the period is taken without raising in_stall and gives no result. A
// tick that completes the period holds in_stall high until its result is registered: S_MUL
// forms setpoint times level, S_DIV_GO loads the divider, the restoring divider finds the 36
// quotient bits at one per cycle, by high_step, and raises its done flag, and S_OUT saturates
// and registers the result; a result still held on the output by out_stall adds its waiting
// time. The user writes registers over the apb port only while idle; nothing enforces it.
module stepped_triangle_output_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic                         in_source_on,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stos_pkg::LEVEL_W-1:0] out_level,
  output logic signed [stos_pkg::DATA_W-1:0] out_scaled_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stos_pkg::ADDR_W-1:0]  paddr,
  input  logic [stos_pkg::DATA_W-1:0]  pwdata,
  output logic [stos_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import stos_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_OUT
  } state_t;

  cfg_t      cfg;
  div_stat_t div_stat;
  logic [MAG_W-1:0] quotient;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [LEVEL_W-1:0]  step_level_r, step_level_nxt;
  logic                falling_r, falling_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;

  logic                accept;
  logic [PERIOD_W-1:0] tc_inc;
  logic                rise_ok, fall_a, fall_ok;
  logic [LEVEL_W-1:0]  lvl_a, lvl_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]   prod_abs;
  logic [DATA_W-1:0]   sat_val;
  logic                div_start;

  stos_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (cfg.high_step),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_stall         = (state_r != S_IDLE);
  assign accept           = in_valid && !in_stall;
  assign div_start        = (state_r == S_DIV_GO);
  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_scaled_value = out_value_r;

  // move rule: climb unless falling or at the top, otherwise fall unless at the bottom
  assign tc_inc  = tick_count_r + PERIOD_W'(1);
  assign rise_ok = (step_level_r < cfg.high_step) && !falling_r;
  assign lvl_a   = rise_ok ? step_level_r + LEVEL_W'(1) : step_level_r;
  assign fall_a  = !rise_ok;
  assign fall_ok = (lvl_a > cfg.low_step) && fall_a;
  assign lvl_b   = fall_ok ? lvl_a - LEVEL_W'(1) : lvl_a;

  assign prod     = PROD_W'($signed(cfg.setpoint)) * PROD_W'($signed({1'b0, step_level_r}));
  assign prod_abs = prod[PROD_W-1] ? (~prod + PROD_W'(1)) : prod;

  // saturate the signed quotient into 32 bits, or give zero when high_step is zero
  always_comb begin
    if (cfg.high_step == '0) begin
      sat_val = '0;
    end else if (neg_r) begin
      if (quotient > MAG_W'(SAT_MIN)) begin
        sat_val = SAT_MIN;
      end else begin
        sat_val = (~quotient[DATA_W-1:0]) + DATA_W'(1);
      end
    end else begin
      if (quotient > MAG_W'(SAT_MAX)) begin
        sat_val = SAT_MAX;
      end else begin
        sat_val = quotient[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    step_level_nxt = step_level_r;
    falling_nxt    = falling_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_level_nxt  = out_level_r;
    out_value_nxt  = out_value_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            step_level_nxt = cfg.low_step;
          end else if (in_source_on) begin
            if (tc_inc < cfg.period_ticks) begin
              tick_count_nxt = tc_inc;
            end else begin
              tick_count_nxt = '0;
              step_level_nxt = lvl_b;
              falling_nxt    = fall_ok;
              state_nxt      = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        mag_nxt   = prod_abs[MAG_W-1:0];
        neg_nxt   = prod[PROD_W-1];
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = step_level_r;
          out_value_nxt = sat_val;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    out_level_r <= out_level_nxt;
    out_value_r <= out_value_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_count_r <= '0;
      step_level_r <= LEVEL_RST;
      falling_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      step_level_r <= step_level_nxt;
      falling_r    <= falling_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the result stage");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_kind && !in_source_on) |=> (state_r == S_IDLE) && $stable(step_level_r)
      && $stable(tick_count_r) && $stable(falling_r))
    else $error("tick with source off changed state");

  a_zero_high: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && (cfg.high_step == '0)) |-> (out_value_r == '0))
    else $error("non-zero result with zero high step");

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the stepped triangle output sequencer
`timescale 1ns / 1ps

module testbench;
  import stos_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 50;
  localparam int ITEM_TARGET  = 1600;
  localparam int ROW_COUNT    = 35;

  localparam logic TICK    = 1'b0;
  localparam logic RESTART = 1'b1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DATA_W-1:0]  value;
  } move_t;

  typedef enum logic {OP_WRITE, OP_SEND} row_op_t;

  typedef struct packed {
    row_op_t            op;
    reg_idx_t           idx;
    logic [DATA_W-1:0]  data;
    logic               kind;
    logic               src_on;
    logic               typed;
    move_t              mv;
  } stim_row_t;

  localparam move_t NO_MOVE = '0;

  // typed rows carry the move that follows at a glance, the rest go through the predictor
  localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_PERIOD,   32'd0,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_HIGH,     32'd20,        TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_SETPOINT, 32'd1000,      TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd2, 32'd100}},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            RESTART, 1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd2, 32'd100}},
    '{OP_WRITE, REG_HIGH,     32'd0,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd1, 32'd0}},
    '{OP_WRITE, REG_HIGH,     32'd31,        TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_LOW,      32'd31,        TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            RESTART, 1'b1, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_SETPOINT, 32'h7FFF_FFFF, TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd31, SAT_MAX}},
    '{OP_WRITE, REG_HIGH,     32'd1,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_LOW,      32'd0,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd30, SAT_MAX}},
    '{OP_WRITE, REG_SETPOINT, 32'h8000_0000, TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b1, '{5'd29, SAT_MIN}},
    '{OP_WRITE, REG_PERIOD,   32'd1023,      TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_PERIOD,   32'd2,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_HIGH,     32'd2,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_LOW,      32'd1,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_SETPOINT, 32'hFFFF_FFF9, TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_WRITE, REG_PERIOD,   32'd1,         TICK,    1'b0, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            RESTART, 1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE},
    '{OP_SEND,  REG_PERIOD,   '0,            TICK,    1'b1, 1'b0, NO_MOVE}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = 1'b0;
  logic                 in_source_on = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_level;
  logic signed [DATA_W-1:0] out_scaled_value;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // predictor copy of the registers and the sequencer state
  cfg_t                 shadow_cfg;
  logic [PERIOD_W-1:0]  tick_cnt;
  logic [LEVEL_W-1:0]   cur_level;
  logic                 going_down;

  move_t pending_moves[$];
  move_t oldest_move;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  requests_sent = 0;
  int  moves_checked = 0;
  int  settings_used = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  stepped_triangle_output_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_source_on     (in_source_on),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level        (out_level),
    .out_scaled_value (out_scaled_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [DATA_W-1:0] scaled_level(input logic [LEVEL_W-1:0] lvl);
    longint prod;
    longint quo;
    if (shadow_cfg.high_step == '0) return '0;
    prod = longint'($signed(shadow_cfg.setpoint)) * longint'(lvl);
    quo = prod / longint'(shadow_cfg.high_step);
    if (quo > longint'($signed(SAT_MAX))) return SAT_MAX;
    if (quo < longint'($signed(SAT_MIN))) return SAT_MIN;
    return DATA_W'(quo);
  endfunction

  function automatic bit advance_sequencer(input logic kind, input logic src_on,
                                           output move_t mv);
    mv = NO_MOVE;
    if (kind == RESTART) begin
      cur_level = shadow_cfg.low_step;
      return 1'b0;
    end
    if (!src_on) return 1'b0;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt < shadow_cfg.period_ticks) return 1'b0;
    tick_cnt = '0;
    // climb, or turn at the top; then fall, or stop falling at the bottom
    if (cur_level < shadow_cfg.high_step && !going_down) begin
      cur_level = cur_level + 1'b1;
    end else begin
      going_down = 1'b1;
    end
    if (cur_level > shadow_cfg.low_step && going_down) begin
      cur_level = cur_level - 1'b1;
    end else begin
      going_down = 1'b0;
    end
    mv.level = cur_level;
    mv.value = scaled_level(cur_level);
    return 1'b1;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input logic kind, input logic src_on, input bit typed,
                              input move_t typed_mv);
    int gap;
    move_t mv;
    bit moved;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_source_on <= src_on;
    do @(posedge clk); while (in_stall);
    moved = advance_sequencer(kind, src_on, mv);
    if (typed) begin
      pending_moves.push_back(typed_mv);
    end else if (moved) begin
      pending_moves.push_back(mv);
    end
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic quiesce(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_moves.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // write then read back one register
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] want_rd;
    logic [DATA_W-1:0] got_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PERIOD:   shadow_cfg.period_ticks = data[PERIOD_W-1:0];
      REG_HIGH:     shadow_cfg.high_step = data[LEVEL_W-1:0];
      REG_LOW:      shadow_cfg.low_step = data[LEVEL_W-1:0];
      REG_SETPOINT: shadow_cfg.setpoint = data;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got_rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_PERIOD:   want_rd = DATA_W'(shadow_cfg.period_ticks);
      REG_HIGH:     want_rd = DATA_W'(shadow_cfg.high_step);
      REG_LOW:      want_rd = DATA_W'(shadow_cfg.low_step);
      REG_SETPOINT: want_rd = shadow_cfg.setpoint;
    endcase
    if (got_rd !== want_rd)
      report_mismatch($sformatf("%s read back %h, wrote %h", idx.name(), got_rd, want_rd));
  endtask

  task automatic pick_setting();
    logic [PERIOD_W-1:0] period;
    logic [LEVEL_W-1:0]  high;
    logic [LEVEL_W-1:0]  low;
    logic [DATA_W-1:0]   sp;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) period = '0;
    else if (r < 14) period = PERIOD_W'(1023);
    else if (r < 20) period = PERIOD_W'($urandom_range(0, 1023));
    else if (r < 75) period = PERIOD_W'($urandom_range(1, 3));
    else period = PERIOD_W'($urandom_range(4, 12));
    r = $urandom_range(0, 99);
    if (r < 10) high = '0;
    else if (r < 18) high = LEVEL_W'(31);
    else if (r < 25) high = LEVEL_W'($urandom_range(0, 31));
    else high = LEVEL_W'($urandom_range(1, 20));
    r = $urandom_range(0, 99);
    if (r < 10) low = '0;
    else if (r < 18) low = LEVEL_W'(31);
    else if (r < 30) low = LEVEL_W'($urandom_range(0, 31));
    else low = LEVEL_W'($urandom_range(1, (high == '0) ? 1 : int'(high)));
    r = $urandom_range(0, 99);
    if (r < 10) sp = SAT_MAX;
    else if (r < 20) sp = SAT_MIN;
    else if (r < 30) sp = '0;
    else if (r < 55) sp = DATA_W'($urandom_range(0, 2000) - 1000);
    else sp = $urandom();
    write_reg(REG_PERIOD, DATA_W'(period));
    write_reg(REG_HIGH, DATA_W'(high));
    write_reg(REG_LOW, DATA_W'(low));
    write_reg(REG_SETPOINT, sp);
    settings_used++;
  endtask

  // result side: random stall, checked against the oldest pending move
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = calm ? 0 : idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("result level %0d value %0d with nothing pending",
                                  out_level, out_scaled_value));
      end else begin
        oldest_move = pending_moves.pop_front();
        if (out_level !== oldest_move.level)
          report_mismatch($sformatf("level %0d, expected %0d", out_level, oldest_move.level));
        if (out_scaled_value !== oldest_move.value)
          report_mismatch($sformatf("scaled value %0d, expected %0d", out_scaled_value,
                                    $signed(oldest_move.value)));
        moves_checked++;
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timed out after %0d cycles with %0d moves pending", cycle_count,
             pending_moves.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int counted;
    int phase_end;
    int r;
    bit dirty;
    shadow_cfg = '{PERIOD_RST, HIGH_RST, LOW_RST, SETPOINT_RST};
    tick_cnt   = '0;
    cur_level  = LEVEL_RST;
    going_down = 1'b0;
    counted    = 0;
    dirty      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].op == OP_WRITE) begin
        if (dirty) quiesce(DRAIN_CYCLES);
        dirty = 1'b0;
        write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
      end else begin
        send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].src_on,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].mv);
        dirty = 1'b1;
      end
    end
    settings_used++;

    while (counted < ITEM_TARGET) begin
      quiesce(DRAIN_CYCLES);
      calm = ($urandom_range(0, 4) == 0);
      pick_setting();
      phase_end = counted + $urandom_range(60, 140);
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (counted < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_request(TICK, 1'b1, 1'b0, NO_MOVE);
        end else if (r < 82) begin
          send_request(RESTART, 1'($urandom_range(0, 1)), 1'b0, NO_MOVE);
        end else begin
          send_request(TICK, 1'b0, 1'b0, NO_MOVE);
        end
        counted++;
        // hold the sender until every move is out
        if ($urandom_range(0, 99) == 0) quiesce(0);
      end
    end

    quiesce(DRAIN_CYCLES);
    $display("run covered %0d requests over %0d register settings in %0d cycles",
             requests_sent, settings_used, cycle_count);
    $display("%0d step moves checked, %0d mismatches", moves_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ stepped_triangle_output_sequencer.f @@
design/stos_pkg.sv
design/stos_cfg_regs.sv
design/stos_div.sv
design/stepped_triangle_output_sequencer.sv
dv/testbench.sv
